>>> hw/rtl/spatial_grid_membership_table_macros.svh
// Assertion macros shared by the grid membership table RTL.
`ifndef SPATIAL_GRID_MEMBERSHIP_TABLE_MACROS_SVH
`define SPATIAL_GRID_MEMBERSHIP_TABLE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SGMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SGMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sgmt_pkg.sv
// Shared types and constants of the grid membership table.
`default_nettype none

package sgmt_pkg;

    localparam int CIDX_W    = 8;
    localparam int CADDR_W   = 20;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 20;
    localparam int ID_W      = 32;
    localparam int IDX_W     = 17;
    localparam int CNT_W     = 12;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_MOVE   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    localparam logic [7:0] NO_TEAM = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_RECIP_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_Z  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACROSS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN     = 2'd3;

    localparam logic [2:0] K_NOP  = 3'd0;
    localparam logic [2:0] K_IGN  = 3'd1;
    localparam logic [2:0] K_ADD  = 3'd2;
    localparam logic [2:0] K_REM  = 3'd3;
    localparam logic [2:0] K_MOVE = 3'd4;

    typedef struct packed {
        logic [15:0] recip_x;
        logic [15:0] recip_z;
        logic [5:0]  across;
        logic [5:0]  down;
    } t_grid_cfg;

    typedef struct packed {
        logic [CIDX_W-1:0]  x0;
        logic [CIDX_W-1:0]  x1;
        logic [CIDX_W-1:0]  z0;
        logic [CIDX_W-1:0]  z1;
        logic               empty;
        logic [CADDR_W-1:0] start;
    } t_span;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] id;
        t_span           a;
        t_span           b;
    } t_job;

endpackage

`default_nettype wire

>>> hw/rtl/sgmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sgmt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/sgmt_front.sv
// Front end: takes items, maps positions to cell spans and queues jobs.
`default_nettype none

module sgmt_front #(
    parameter int TEAMS       = 8,
    parameter int MAX_CELLS_X = 32,
    parameter int MAX_CELLS_Z = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sgmt_pkg::t_grid_cfg              i_cfg,
    input  logic                             i_enable,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_cmd,
    input  logic [sgmt_pkg::ID_W-1:0]        i_object_id,
    input  logic [7:0]                       i_team,
    input  logic [sgmt_pkg::POS_W-1:0]       i_pos_x,
    input  logic [sgmt_pkg::POS_W-1:0]       i_pos_z,
    input  logic [sgmt_pkg::POS_W-1:0]       i_old_x,
    input  logic [sgmt_pkg::POS_W-1:0]       i_old_z,
    input  logic [sgmt_pkg::POS_W-1:0]       i_radius,
    output logic                             o_push,
    output sgmt_pkg::t_job                   o_job,
    input  logic                             i_full
);
    import sgmt_pkg::*;

    localparam int TW     = (TEAMS > 1) ? $clog2(TEAMS) : 1;
    localparam int NCELLS = TEAMS * MAX_CELLS_X * MAX_CELLS_Z;
    localparam int CAW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int PROD_W = POS_W + 2 + 16;

    function automatic logic [8:0] last_cell(input logic [5:0] n, input logic [8:0] maxc);
        logic [8:0] e;
        if (n == 6'd0) begin
            e = 9'd1;
        end else if ({3'b000, n} > maxc) begin
            e = maxc;
        end else begin
            e = {3'b000, n};
        end
        return e - 9'd1;
    endfunction

    // Stage 1: the accepted item. Coordinates: 0 pos_x, 1 pos_z, 2 old_x, 3 old_z.
    logic             r1_valid;
    logic [1:0]       r1_cmd;
    logic [ID_W-1:0]  r1_id;
    logic [7:0]       r1_team;
    logic [POS_W-1:0] r1_coord [4];
    logic [POS_W-1:0] r1_rad;

    // Stage 2: raw cell indices of both span ends.
    logic             r2_valid;
    logic [1:0]       r2_cmd;
    logic [ID_W-1:0]  r2_id;
    logic             r2_ign;
    logic [TW-1:0]    r2_team;
    logic             r2_rz;
    logic [IDX_W-1:0] r2_ilo [4];
    logic [IDX_W-1:0] r2_ihi [4];

    logic adv1, adv2;
    logic [POS_W:0]    p2     [4];
    logic [POS_W+1:0]  lo_v   [4];
    logic [POS_W+1:0]  hi_v   [4];
    logic [15:0]       rc     [4];
    logic [PROD_W-1:0] prod_lo [4];
    logic [PROD_W-1:0] prod_hi [4];

    assign adv2    = !r2_valid || !i_full;
    assign adv1    = !r1_valid || adv2;
    assign o_ready = i_enable && adv1;
    assign o_push  = r2_valid && !i_full;

    // Bounds in Q21.1: 2*pos -/+ radius, low end saturating at zero.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            p2[k]      = {r1_coord[k], 1'b0};
            rc[k]      = (k == 0 || k == 2) ? i_cfg.recip_x : i_cfg.recip_z;
            lo_v[k]    = (p2[k] < {1'b0, r1_rad}) ? '0
                         : ((POS_W+2)'(p2[k]) - (POS_W+2)'(r1_rad));
            hi_v[k]    = (POS_W+2)'(p2[k]) + (POS_W+2)'(r1_rad);
            prod_lo[k] = PROD_W'(lo_v[k]) * PROD_W'(rc[k]);
            prod_hi[k] = PROD_W'(hi_v[k]) * PROD_W'(rc[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r1_valid <= i_valid && i_enable;
            end
            if (adv2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r1_cmd      <= i_cmd;
            r1_id       <= i_object_id;
            r1_team     <= i_team;
            r1_coord[0] <= i_pos_x;
            r1_coord[1] <= i_pos_z;
            r1_coord[2] <= i_old_x;
            r1_coord[3] <= i_old_z;
            r1_rad      <= i_radius;
        end
        if (adv2 && r1_valid) begin
            r2_cmd  <= r1_cmd;
            r2_id   <= r1_id;
            r2_ign  <= (r1_team == NO_TEAM) || ({1'b0, r1_team} >= 9'(TEAMS));
            r2_team <= r1_team[TW-1:0];
            r2_rz   <= (r1_rad == '0);
            for (int k = 0; k < 4; k++) begin
                r2_ilo[k] <= prod_lo[k][PROD_W-1 -: IDX_W];
                r2_ihi[k] <= prod_hi[k][PROD_W-1 -: IDX_W];
            end
        end
    end

    // Stage 2: clamp to the grid in use and build the job.
    logic [8:0]     lastx, lastz;
    logic [8:0]     hi_c [4];
    logic [8:0]     lo_c [4];
    logic           emp  [4];
    logic [CAW-1:0] base;
    logic           same_cell;
    t_span          sp_new, sp_old;

    always_comb begin
        lastx = last_cell(i_cfg.across, 9'(MAX_CELLS_X));
        lastz = last_cell(i_cfg.down, 9'(MAX_CELLS_Z));
        for (int k = 0; k < 4; k++) begin
            logic [8:0] lst;
            lst     = (k == 0 || k == 2) ? lastx : lastz;
            hi_c[k] = (r2_ihi[k] > IDX_W'(lst)) ? lst : r2_ihi[k][8:0];
            lo_c[k] = r2_rz ? hi_c[k] : r2_ilo[k][8:0];
            emp[k]  = !r2_rz && (r2_ilo[k] > IDX_W'(hi_c[k]));
        end
        base = CAW'(r2_team) * CAW'(MAX_CELLS_X * MAX_CELLS_Z);

        sp_new.x0    = CIDX_W'(lo_c[0]);
        sp_new.x1    = CIDX_W'(hi_c[0]);
        sp_new.z0    = CIDX_W'(lo_c[1]);
        sp_new.z1    = CIDX_W'(hi_c[1]);
        sp_new.empty = emp[0] || emp[1];
        sp_new.start = CADDR_W'(base + CAW'(lo_c[1]) * CAW'(MAX_CELLS_X) + CAW'(lo_c[0]));

        sp_old.x0    = CIDX_W'(lo_c[2]);
        sp_old.x1    = CIDX_W'(hi_c[2]);
        sp_old.z0    = CIDX_W'(lo_c[3]);
        sp_old.z1    = CIDX_W'(hi_c[3]);
        sp_old.empty = emp[2] || emp[3];
        sp_old.start = CADDR_W'(base + CAW'(lo_c[3]) * CAW'(MAX_CELLS_X) + CAW'(lo_c[2]));

        // With a zero radius the low ends are the clamped single cells.
        same_cell = r2_rz && (lo_c[0] == lo_c[2]) && (lo_c[1] == lo_c[3]);

        o_job.id = r2_id;
        o_job.a  = sp_new;
        o_job.b  = sp_new;
        priority if (r2_ign) begin
            o_job.kind = K_IGN;
        end else if (r2_cmd == CMD_ADD) begin
            o_job.kind = K_ADD;
        end else if (r2_cmd == CMD_REMOVE) begin
            o_job.kind = K_REM;
        end else if (r2_cmd == CMD_MOVE && !same_cell) begin
            o_job.kind = K_MOVE;
            o_job.a    = sp_old;
        end else begin
            o_job.kind = K_NOP;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sgmt_queue.sv
// Short job queue between the front end and the cell engine.
`default_nettype none

module sgmt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sgmt_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output sgmt_pkg::t_job o_job,
    input  logic           i_pop
);
    import sgmt_pkg::*;

`include "spatial_grid_membership_table_macros.svh"

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `SGMT_ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `SGMT_ASSERT_IMPL(a_q_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `SGMT_ASSERT_NEXT(a_q_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not rise")

endmodule

`default_nettype wire

>>> hw/rtl/sgmt_back.sv
// Cell engine: walks the cell spans of each job and updates the slot tables.
`default_nettype none

module sgmt_back #(
    parameter int TEAMS          = 8,
    parameter int MAX_CELLS_X    = 32,
    parameter int MAX_CELLS_Z    = 32,
    parameter int SLOTS_PER_CELL = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    output logic                       o_init_done,
    input  logic                       i_valid,
    output logic                       o_pop,
    input  sgmt_pkg::t_job             i_job,
    output logic                       o_m_valid,
    input  logic                       i_m_ready,
    output logic [1:0]                 o_status,
    output logic [sgmt_pkg::CNT_W-1:0] o_touched
);
    import sgmt_pkg::*;

`include "spatial_grid_membership_table_macros.svh"

    localparam int S      = SLOTS_PER_CELL;
    localparam int SW     = $clog2(S);
    localparam int NFW    = $clog2(S + 1);
    localparam int NCELLS = TEAMS * MAX_CELLS_X * MAX_CELLS_Z;
    localparam int CAW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int ROW_W  = S + S * NFW + NFW;

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_START = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_LOAD  = 4'd4;
    localparam logic [3:0] ST_ADD   = 4'd5;
    localparam logic [3:0] ST_SCAN  = 4'd6;
    localparam logic [3:0] ST_DRAIN = 4'd7;
    localparam logic [3:0] ST_WB    = 4'd8;
    localparam logic [3:0] ST_RES   = 4'd9;

    logic [3:0]              r_state, n_state;
    logic [CAW-1:0]          r_init, n_init;
    t_job                    r_job, n_job;
    logic                    r_phase, n_phase;
    logic [CIDX_W-1:0]       r_x, n_x, r_z, n_z;
    logic [CAW-1:0]          r_cell, n_cell, r_col, n_col;
    logic [S-1:0]            r_used, n_used;
    logic [S-1:0][NFW-1:0]   r_next, n_next;
    logic [NFW-1:0]          r_head, n_head;
    logic [SW-1:0]           r_slot, n_slot, r_cs, n_cs;
    logic                    r_cv, n_cv;
    logic                    r_found, n_found, r_full, n_full, r_miss, n_miss;
    logic [CNT_W-1:0]        r_touched, n_touched;
    logic                    r_ovalid, n_ovalid;
    logic [1:0]              r_ostatus, n_ostatus;
    logic [CNT_W-1:0]        r_otouched, n_otouched;

    logic                    row_we, id_we;
    logic [CAW-1:0]          row_waddr;
    logic [ROW_W-1:0]        row_wdata, row_rdata;
    logic [ID_W-1:0]         id_rdata;
    logic [S-1:0][NFW-1:0]   init_next;
    t_span                   sp;
    logic                    is_add;

    // Per-cell row: used bits, free-list links and free-list head.
    sgmt_ram #(.W(ROW_W), .D(NCELLS)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (r_cell),
        .o_rdata (row_rdata)
    );

    // Object ids, one word per slot.
    sgmt_ram #(.W(ID_W), .D(NCELLS * (2 ** SW))) u_ids (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr ({r_cell, r_head[SW-1:0]}),
        .i_wdata (r_job.id),
        .i_raddr ({r_cell, r_slot}),
        .o_rdata (id_rdata)
    );

    always_comb begin
        for (int i = 0; i < S; i++) begin
            init_next[i] = NFW'(i + 1);
        end
    end

    assign sp          = r_phase ? r_job.b : r_job.a;
    assign is_add      = (r_job.kind == K_ADD) || ((r_job.kind == K_MOVE) && r_phase);
    assign row_waddr   = (r_state == ST_INIT) ? r_init : r_cell;
    assign row_wdata   = (r_state == ST_INIT) ? {NFW'(0), init_next, {S{1'b0}}}
                                              : {r_head, r_next, r_used};
    assign o_init_done = (r_state != ST_INIT);
    assign o_m_valid   = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_touched   = r_otouched;

    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_job      = r_job;
        n_phase    = r_phase;
        n_x        = r_x;
        n_z        = r_z;
        n_cell     = r_cell;
        n_col      = r_col;
        n_used     = r_used;
        n_next     = r_next;
        n_head     = r_head;
        n_slot     = r_slot;
        n_cs       = r_cs;
        n_cv       = r_cv;
        n_found    = r_found;
        n_full     = r_full;
        n_miss     = r_miss;
        n_touched  = r_touched;
        n_ovalid   = r_ovalid && !i_m_ready;
        n_ostatus  = r_ostatus;
        n_otouched = r_otouched;
        row_we     = 1'b0;
        id_we      = 1'b0;
        o_pop      = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                row_we = 1'b1;
                if (r_init == CAW'(NCELLS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_init = r_init + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_job     = i_job;
                    n_phase   = 1'b0;
                    n_full    = 1'b0;
                    n_miss    = 1'b0;
                    n_touched = '0;
                    if (i_job.kind == K_NOP || i_job.kind == K_IGN) begin
                        n_state = ST_RES;
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                if (sp.empty) begin
                    if (!r_phase && r_job.kind == K_MOVE) begin
                        n_phase = 1'b1;
                    end else begin
                        n_state = ST_RES;
                    end
                end else begin
                    n_x     = sp.x0;
                    n_z     = sp.z0;
                    n_cell  = sp.start[CAW-1:0];
                    n_col   = sp.start[CAW-1:0];
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_used  = row_rdata[S-1:0];
                n_next  = row_rdata[S+S*NFW-1:S];
                n_head  = row_rdata[ROW_W-1 -: NFW];
                n_cv    = 1'b0;
                n_slot  = '0;
                n_found = 1'b0;
                n_state = is_add ? ST_ADD : ST_SCAN;
            end
            ST_ADD: begin
                if (r_head < NFW'(S)) begin
                    id_we                   = 1'b1;
                    n_used[r_head[SW-1:0]]  = 1'b1;
                    n_head                  = r_next[r_head[SW-1:0]];
                end else begin
                    n_full = 1'b1;
                end
                n_state = ST_WB;
            end
            ST_SCAN, ST_DRAIN: begin
                // The id read issued last cycle is compared now.
                if (r_cv && r_used[r_cs] && id_rdata == r_job.id) begin
                    n_used[r_cs] = 1'b0;
                    n_next[r_cs] = r_head;
                    n_head       = NFW'(r_cs);
                    n_found      = 1'b1;
                end
                if (r_state == ST_SCAN) begin
                    n_cv = 1'b1;
                    n_cs = r_slot;
                    if (r_slot == SW'(S - 1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end else begin
                    n_cv    = 1'b0;
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                row_we    = 1'b1;
                n_touched = (r_touched == {CNT_W{1'b1}}) ? r_touched : r_touched + 1'b1;
                if (!is_add && !r_found) begin
                    n_miss = 1'b1;
                end
                if (r_z < sp.z1) begin
                    n_z     = r_z + 1'b1;
                    n_cell  = r_cell + CAW'(MAX_CELLS_X);
                    n_state = ST_RD;
                end else if (r_x < sp.x1) begin
                    n_x     = r_x + 1'b1;
                    n_z     = sp.z0;
                    n_col   = r_col + 1'b1;
                    n_cell  = r_col + 1'b1;
                    n_state = ST_RD;
                end else if (!r_phase && r_job.kind == K_MOVE) begin
                    n_phase = 1'b1;
                    n_state = ST_START;
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (!r_ovalid || i_m_ready) begin
                    n_ovalid   = 1'b1;
                    n_otouched = r_touched;
                    priority if (r_job.kind == K_IGN) begin
                        n_ostatus = STAT_IGNORED;
                    end else if (r_full) begin
                        n_ostatus = STAT_FULL;
                    end else if (r_miss) begin
                        n_ostatus = STAT_MISSING;
                    end else begin
                        n_ostatus = STAT_OK;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_init   <= '0;
            r_ovalid <= 1'b0;
            r_cv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            r_cv     <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_phase    <= n_phase;
        r_x        <= n_x;
        r_z        <= n_z;
        r_cell     <= n_cell;
        r_col      <= n_col;
        r_used     <= n_used;
        r_next     <= n_next;
        r_head     <= n_head;
        r_slot     <= n_slot;
        r_cs       <= n_cs;
        r_found    <= n_found;
        r_full     <= n_full;
        r_miss     <= n_miss;
        r_touched  <= n_touched;
        r_ostatus  <= n_ostatus;
        r_otouched <= n_otouched;
    end

    `SGMT_ASSERT_IMPL(a_pop_only_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE, "job taken outside idle")
    `SGMT_ASSERT_IMPL(a_init_quiet, i_clk, i_rst_n, r_state == ST_INIT, !o_pop && !id_we, "activity during clearing pass")
    `SGMT_ASSERT_NEXT(a_wb_counts, i_clk, i_rst_n, r_state == ST_WB, r_touched != '0, "visited cell not counted")

endmodule

`default_nettype wire

>>> hw/rtl/spatial_grid_membership_table.sv
// An accepted item passes the front end and the job queue to the cell engine, which starts each
// span it walks, then per cell reads the row, takes a free slot for an add or scans every slot
// for a remove, and writes the row back; last it gives the result. An ignored or idle item goes
// straight to the result; a move walks two spans. Throughput: one item at a time in the cell
// engine; the per-cell slot scan through the id memory's single read port sets the rate. Up to
// 4 jobs queue ahead of it. Reset: after i_rst_n is released a clearing pass writes every cell
// row, all TEAMS * MAX_CELLS_X * MAX_CELLS_Z of them, while no item is accepted.
`default_nettype none

module spatial_grid_membership_table #(
    parameter int TEAMS          = 8,
    parameter int MAX_CELLS_X    = 32,
    parameter int MAX_CELLS_Z    = 32,
    parameter int SLOTS_PER_CELL = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [sgmt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgmt_pkg::CFG_W-1:0]       i_cfg_data,
    // Item input stream.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // object_id[31:0], team[39:32], pos_x[59:40], pos_z[79:60], old_x[99:80],
    // old_z[119:100], radius[139:120], zero pad[143:140]
    input  logic [143:0]                     i_s_tdata,
    // cmd[1:0]
    input  logic [1:0]                       i_s_tuser,
    // Result stream.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status[1:0], cells_touched[13:2], zero pad[15:14]
    output logic [15:0]                      o_m_tdata
);
    import sgmt_pkg::*;

    // Grid config, to be written only while the block is idle: the user's duty, unchecked.
    logic [15:0] r_recip_x, r_recip_z;
    logic [5:0]  r_across, r_down;
    t_grid_cfg   cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_x <= 16'd4096;
            r_recip_z <= 16'd4096;
            r_across  <= 6'd32;
            r_down    <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RECIP_X: r_recip_x <= i_cfg_data;
                REG_RECIP_Z: r_recip_z <= i_cfg_data;
                REG_ACROSS:  r_across  <= i_cfg_data[5:0];
                REG_DOWN:    r_down    <= i_cfg_data[5:0];
            endcase
        end
    end

    assign cfg.recip_x = r_recip_x;
    assign cfg.recip_z = r_recip_z;
    assign cfg.across  = r_across;
    assign cfg.down    = r_down;

    logic init_done;
    logic q_push, q_full, q_valid, q_pop;
    t_job front_job, q_job;
    logic [1:0]       status;
    logic [CNT_W-1:0] touched;

    // The front end classifies items and turns positions into cell spans.
    sgmt_front #(
        .TEAMS       (TEAMS),
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Z (MAX_CELLS_Z)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_enable    (init_done),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_cmd       (i_s_tuser),
        .i_object_id (i_s_tdata[31:0]),
        .i_team      (i_s_tdata[39:32]),
        .i_pos_x     (i_s_tdata[59:40]),
        .i_pos_z     (i_s_tdata[79:60]),
        .i_old_x     (i_s_tdata[99:80]),
        .i_old_z     (i_s_tdata[119:100]),
        .i_radius    (i_s_tdata[139:120]),
        .o_push      (q_push),
        .o_job       (front_job),
        .i_full      (q_full)
    );

    // The queue lets the front end keep taking items during long slot scans.
    sgmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // The cell engine owns both memories and the result register.
    sgmt_back #(
        .TEAMS          (TEAMS),
        .MAX_CELLS_X    (MAX_CELLS_X),
        .MAX_CELLS_Z    (MAX_CELLS_Z),
        .SLOTS_PER_CELL (SLOTS_PER_CELL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init_done (init_done),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_job       (q_job),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_status    (status),
        .o_touched   (touched)
    );

    assign o_m_tdata = {2'b00, touched, status};

endmodule

`default_nettype wire

>>> bench/tb_spatial_grid_membership_table.sv
// Self-checking testbench of the per-team spatial grid membership table.
`default_nettype none

module tb_spatial_grid_membership_table;
    timeunit 1ns;
    timeprecision 1ps;

    import sgmt_pkg::*;

    localparam int TEAMS_N = 8;
    localparam int NX_MAX = 32;
    localparam int NZ_MAX = 32;
    localparam int SLOTS = 16;
    localparam int NCELLS = TEAMS_N * NX_MAX * NZ_MAX;
    localparam int SLOT_END = SLOTS;
    // Unused command code: the block does nothing and reports ok.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Expected result of one item.
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] touched;
    } t_outcome;

    // Grid contents and settings mirrored on the bench side, with the
    // predicted outcomes queued in order of acceptance.
    class grid_scoreboard;
        logic [31:0] ids [NCELLS*SLOTS];
        bit          used [NCELLS*SLOTS];
        int          link [NCELLS*SLOTS];
        int          head [NCELLS];
        t_grid_cfg   cfg;
        t_outcome    pending [$];
        int          errors;

        function void clear();
            for (int c = 0; c < NCELLS; c++) begin
                head[c] = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    used[c*SLOTS+i] = 0;
                    ids[c*SLOTS+i] = '0;
                    link[c*SLOTS+i] = i + 1;
                end
            end
            cfg = '{recip_x: 16'd4096, recip_z: 16'd4096, across: 6'd32, down: 6'd32};
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_RECIP_X: cfg.recip_x = val;
                REG_RECIP_Z: cfg.recip_z = val;
                REG_ACROSS:  cfg.across = val[5:0];
                default:     cfg.down = val[5:0];
            endcase
        endfunction

        function int cells_in_use(logic [5:0] v, int maxc);
            if (v == 0) return 1;
            if (v > maxc) return maxc;
            return v;
        endfunction

        // Cell span along one axis; lo > hi means nothing is covered.
        function void span(logic [19:0] pos, logic [19:0] rad, logic [15:0] recip,
                           int n, output longint lo, output longint hi);
            longint p2;
            p2 = longint'(pos) * 2;
            if (rad == 0) begin
                lo = (p2 * recip) >>> 21;
                if (lo > n - 1) lo = n - 1;
                hi = lo;
            end else begin
                lo = (p2 < rad) ? 0 : ((p2 - rad) * recip) >>> 21;
                hi = ((p2 + rad) * recip) >>> 21;
                if (hi > n - 1) hi = n - 1;
            end
        endfunction

        function int walk_cells(bit add, logic [31:0] id, int team, logic [19:0] px,
                                logic [19:0] pz, logic [19:0] rad, ref bit flag);
            longint x0, x1, z0, z1;
            int cnt, c, s;
            bit hit;
            cnt = 0;
            span(px, rad, cfg.recip_x, cells_in_use(cfg.across, NX_MAX), x0, x1);
            span(pz, rad, cfg.recip_z, cells_in_use(cfg.down, NZ_MAX), z0, z1);
            for (longint x = x0; x <= x1; x++) begin
                for (longint z = z0; z <= z1; z++) begin
                    c = (team * NZ_MAX + int'(z)) * NX_MAX + int'(x);
                    if (add) begin
                        if (head[c] >= SLOT_END) flag = 1;
                        else begin
                            s = c * SLOTS + head[c];
                            head[c] = link[s];
                            ids[s] = id;
                            used[s] = 1;
                        end
                    end else begin
                        hit = 0;
                        for (int i = 0; i < SLOTS; i++) begin
                            s = c * SLOTS + i;
                            if (used[s] && ids[s] == id) begin
                                used[s] = 0;
                                link[s] = head[c];
                                head[c] = i;
                                hit = 1;
                            end
                        end
                        if (!hit) flag = 1;
                    end
                    cnt++;
                end
            end
            return cnt;
        endfunction

        // Notes an accepted item and queues the outcome it must produce.
        function void note_item(logic [1:0] cmd, logic [143:0] d);
            logic [31:0] id;
            int team, touched, nx, nz;
            logic [19:0] px, pz, ox, oz, rad;
            longint a0, a1, b0, b1, c0, c1, e0, e1;
            bit full, missing;
            t_outcome o;
            id = d[31:0];
            team = int'(d[39:32]);
            px = d[59:40];
            pz = d[79:60];
            ox = d[99:80];
            oz = d[119:100];
            rad = d[139:120];
            full = 0;
            missing = 0;
            touched = 0;
            if (team >= TEAMS_N) begin
                pending.push_back('{status: STAT_IGNORED, touched: 12'd0});
                return;
            end
            if (cmd == CMD_ADD) touched = walk_cells(1, id, team, px, pz, rad, full);
            else if (cmd == CMD_REMOVE) touched = walk_cells(0, id, team, px, pz, rad, missing);
            else if (cmd == CMD_MOVE) begin
                nx = cells_in_use(cfg.across, NX_MAX);
                nz = cells_in_use(cfg.down, NZ_MAX);
                span(ox, 0, cfg.recip_x, nx, a0, a1);
                span(oz, 0, cfg.recip_z, nz, b0, b1);
                span(px, 0, cfg.recip_x, nx, c0, c1);
                span(pz, 0, cfg.recip_z, nz, e0, e1);
                if (a0 != c0 || b0 != e0 || rad != 0) begin
                    touched = walk_cells(0, id, team, ox, oz, rad, missing);
                    touched += walk_cells(1, id, team, px, pz, rad, full);
                end
            end
            o.status = full ? STAT_FULL : (missing ? STAT_MISSING : STAT_OK);
            o.touched = (touched > 4095) ? 12'd4095 : touched[11:0];
            pending.push_back(o);
        endfunction

        function void check_result(logic [15:0] d);
            t_outcome want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d touched %0d",
                         $time, d[1:0], d[13:2]);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (d[1:0] !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, d[1:0]);
                errors++;
            end
            if (d[13:2] !== want.touched) begin
                $display("%0t: cells_touched mismatch, expected %0d, actual %0d",
                         $time, want.touched, d[13:2]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [1:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [15:0]  o_m_tdata;

    // Idle percentages of each side; the receiver can also be held off.
    int  send_idle = 35;
    int  recv_idle = 51;
    bit  hold_off = 0;
    grid_scoreboard board;

    spatial_grid_membership_table dut (.*);

    always #6 i_clk = ~i_clk;

    // Receiver: ready toggles at random, held low during a hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
        i_m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // Hold-off of the receiver, counted here in cycles, while the sender runs on.
    initial begin
        wait (send_idle == 0 && recv_idle == 0);
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    // Sends one item, with random idle cycles ahead of it.
    task automatic send_item(logic [1:0] cmd, logic [31:0] id, logic [7:0] team,
                             logic [19:0] px, logic [19:0] pz, logic [19:0] ox,
                             logic [19:0] oz, logic [19:0] rad);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= cmd;
        i_s_tdata <= {4'd0, rad, oz, ox, pz, px, team, id};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_item(cmd, {4'd0, rad, oz, ox, pz, px, team, id});
    endtask

    // Waits until every expected result has come, then lets the engine settle.
    task automatic drain();
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.write_reg(idx, val);
    endtask

    // Random item from a small pool of ids and places so that removes find
    // their matches and cells fill up; a little noise besides.
    task automatic random_item();
        logic [1:0] cmd;
        logic [31:0] id;
        logic [7:0] team;
        logic [19:0] px, pz, ox, oz, rad;
        int r;
        r = $urandom_range(99);
        cmd = (r < 45) ? CMD_ADD : (r < 75) ? CMD_REMOVE : (r < 97) ? CMD_MOVE : CMD_UNUSED;
        id = ($urandom_range(9) == 0) ? $urandom : $urandom_range(7);
        team = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1));
        px = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(2047));
        pz = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(2047));
        ox = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(2047));
        oz = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(2047));
        r = $urandom_range(19);
        rad = (r < 11) ? 20'd0 : (r < 19) ? 20'($urandom_range(1023)) : 20'($urandom);
        send_item(cmd, id, team, px, pz, ox, oz, rad);
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // Extremes, each command, ignored teams, full cells, missing ids.
        send_item(CMD_ADD, 32'hFFFF_FFFF, 8'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        send_item(CMD_ADD, 32'h0, 8'd7, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0, 20'd0);
        send_item(CMD_REMOVE, 32'h1234, 8'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        send_item(CMD_ADD, 32'd5, 8'd255, 20'd5, 20'd5, 20'd0, 20'd0, 20'd0);
        send_item(CMD_ADD, 32'd5, 8'd8, 20'd5, 20'd5, 20'd0, 20'd0, 20'd0);
        send_item(CMD_UNUSED, 32'd5, 8'd1, 20'd5, 20'd5, 20'd0, 20'd0, 20'd0);
        for (int i = 0; i < 17; i++)
            send_item(CMD_ADD, 32'(i), 8'd2, 20'd100, 20'd100, 20'd0, 20'd0, 20'd0);
        send_item(CMD_MOVE, 32'd3, 8'd2, 20'd101, 20'd101, 20'd100, 20'd100, 20'd0);
        send_item(CMD_MOVE, 32'd3, 8'd2, 20'd900, 20'd40, 20'd100, 20'd100, 20'd0);
        send_item(CMD_ADD, 32'd9, 8'd3, 20'd50, 20'd50, 20'd0, 20'd0, 20'hFFFFF);
        send_item(CMD_MOVE, 32'd9, 8'd3, 20'd800, 20'd700, 20'd50, 20'd50, 20'hFFFFF);
        drain();

        // Several settings, the extremes among them, each followed by random items.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin write_reg(REG_RECIP_X, 16'hFFFF); write_reg(REG_RECIP_Z, 16'h0);
                         write_reg(REG_ACROSS, 16'd0); write_reg(REG_DOWN, 16'd63); end
                1: begin write_reg(REG_RECIP_X, 16'd40000); write_reg(REG_RECIP_Z, 16'd65535);
                         write_reg(REG_ACROSS, 16'd1); write_reg(REG_DOWN, 16'd32); end
                2: begin write_reg(REG_RECIP_X, 16'd8192); write_reg(REG_RECIP_Z, 16'd12000);
                         write_reg(REG_ACROSS, 16'd5); write_reg(REG_DOWN, 16'd3); end
                3: begin send_idle = 51; recv_idle = 35; end
                4: begin send_idle = 0; recv_idle = 0; end
                default: begin write_reg(REG_RECIP_X, 16'($urandom));
                         write_reg(REG_RECIP_Z, 16'($urandom));
                         write_reg(REG_ACROSS, 16'($urandom));
                         write_reg(REG_DOWN, 16'($urandom)); end
            endcase
            for (int n = 0; n < 90; n++) random_item();
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[spatial_grid_membership_table] OK");
        else
            $display("[spatial_grid_membership_table] ERROR");
        $finish;
    end

    initial begin
        #2000ms;
        $display("[spatial_grid_membership_table] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
